[sv/fpp_pkg.sv]
// shared constants, tables and multiplier helpers for the fisheye projection pipeline
`default_nettype none

package fpp_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int DIV_STEPS    = 25;
    localparam int HORNER_STEPS = 4;
    localparam int LATENCY      = 82;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_DIST_K0  = 3'd4;
    localparam logic [2:0] CFG_DIST_K1  = 3'd5;
    localparam logic [2:0] CFG_DIST_K2  = 3'd6;
    localparam logic [2:0] CFG_DIST_K3  = 3'd7;

    typedef logic signed [43:0] t_mop;
    typedef logic signed [29:0] t_mcoef;

    // carry of the point through the root and arctangent stages
    typedef struct packed {
        logic        sx;
        logic        sy;
        logic        sz;
        logic        zero;
        logic [31:0] x_n;
        logic [31:0] y_n;
        logic [4:0]  k;
        logic [31:0] b_s;
    } t_car;

    // carry through the polynomial stages
    typedef struct packed {
        logic [25:0]        t;
        logic [27:0]        t2;
        logic signed [25:0] cosv;
        logic signed [25:0] sinv;
    } t_pol;

    // truncated q.30 arctangent of 2^-i
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] v;
        case (i)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd7;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // wide product split in two partial products, joined in the next stage
    function automatic logic signed [52:0] mul_lo(input t_mop a, input t_mcoef b);
        logic signed [22:0] al;
        al = $signed({1'b0, a[21:0]});
        return al * b;
    endfunction

    function automatic logic signed [51:0] mul_hi(input t_mop a, input t_mcoef b);
        logic signed [21:0] ah;
        ah = $signed(a[43:22]);
        return ah * b;
    endfunction

    function automatic logic signed [73:0] mul_join(input logic signed [52:0] lo,
                                                    input logic signed [51:0] hi);
        logic signed [73:0] h;
        h = $signed({hi, 22'd0});
        return h + 74'(lo);
    endfunction

endpackage

`default_nettype wire

[sv/fisheye_point_projection_top.sv]
// fisheye (odd-polynomial) projection of a 3d point to a pixel position
// throughput: one item per cycle while the output is not stalled
// 32 root stages and 28 arctangent stages set the depth
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// synchronous active-low reset clears valid bits and loads register defaults
`default_nettype none

module fisheye_point_projection_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // point_x, point_y, point_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // pixel_u, pixel_v
    output logic             m_axis_tuser   // saturated
);
    import fpp_pkg::*;

    logic en;
    logic [LATENCY-1:0] r_vld;

    logic [23:0] r_fx, r_fy, r_cx, r_cy, r_k0, r_k1, r_k2, r_k3;

    assign en            = ~r_vld[LATENCY-1] | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= 24'd256;
            r_fy <= 24'd256;
            r_cx <= '0;
            r_cy <= '0;
            r_k0 <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FOCAL_X:  r_fx <= i_cfg_data;
                CFG_FOCAL_Y:  r_fy <= i_cfg_data;
                CFG_CENTER_X: r_cx <= i_cfg_data;
                CFG_CENTER_Y: r_cy <= i_cfg_data;
                CFG_DIST_K0:  r_k0 <= i_cfg_data;
                CFG_DIST_K1:  r_k1 <= i_cfg_data;
                CFG_DIST_K2:  r_k2 <= i_cfg_data;
                CFG_DIST_K3:  r_k3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage a: magnitudes and signs
    logic [31:0] in_x, in_y, in_z;
    logic [31:0] r_a_ax, r_a_ay, r_a_az;
    logic        r_a_sx, r_a_sy, r_a_sz;

    assign in_x = s_axis_tdata[31:0];
    assign in_y = s_axis_tdata[63:32];
    assign in_z = s_axis_tdata[95:64];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ax <= in_x[31] ? 32'(-in_x) : in_x;
            r_a_ay <= in_y[31] ? 32'(-in_y) : in_y;
            r_a_az <= in_z[31] ? 32'(-in_z) : in_z;
            r_a_sx <= in_x[31];
            r_a_sy <= in_y[31];
            r_a_sz <= in_z[31];
        end
    end

    // stage b: normalize (x, y): the larger magnitude reaches bit 30, or bit 31 at 2^31
    logic [31:0] b_m;
    logic [5:0]  b_lz;
    logic [4:0]  b_s;
    logic [62:0] n_b_bz;
    logic [62:0] r_b_bz;
    t_car        n_b_car, r_b_car;

    always_comb begin
        b_m  = r_a_ax | r_a_ay;
        b_lz = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (b_m[i]) begin
                b_lz = 6'(31 - i);
            end
        end
        b_s = (b_lz == 6'd0) ? 5'd0 : 5'(b_lz - 6'd1);
        n_b_car       = '0;
        n_b_car.sx    = r_a_sx;
        n_b_car.sy    = r_a_sy;
        n_b_car.sz    = r_a_sz;
        n_b_car.zero  = (b_m == 32'd0);
        n_b_car.x_n   = r_a_ax << b_s;
        n_b_car.y_n   = r_a_ay << b_s;
        n_b_bz        = {31'd0, r_a_az} << b_s;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_car <= n_b_car;
            r_b_bz  <= n_b_bz;
        end
    end

    // stage c: squares, and the common shift that brings z below 2^32
    logic [5:0]  c_hb;
    logic [4:0]  c_k;
    t_car        n_c_car, r_c_car;
    logic [63:0] r_c_xx, r_c_yy;

    always_comb begin
        c_hb = '0;
        for (int i = 0; i < 63; i++) begin
            if (r_b_bz[i]) begin
                c_hb = 6'(i);
            end
        end
        c_k          = (c_hb > 6'd31) ? 5'(c_hb - 6'd31) : 5'd0;
        n_c_car      = r_b_car;
        n_c_car.k    = c_k;
        n_c_car.b_s  = 32'(r_b_bz >> c_k);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_car <= n_c_car;
            r_c_xx  <= r_b_car.x_n * r_b_car.x_n;
            r_c_yy  <= r_b_car.y_n * r_b_car.y_n;
        end
    end

    // stage d and root pipeline: one result bit per stage
    logic [63:0] r_sq_n   [0:SQRT_STEPS];
    logic [63:0] r_sq_res [0:SQRT_STEPS];
    t_car        r_sq_car [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_n[0]   <= r_c_xx + r_c_yy;
            r_sq_res[0] <= '0;
            r_sq_car[0] <= r_c_car;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
        logic [63:0] trial;
        logic        take;
        assign trial = r_sq_res[j] + BIT;
        assign take  = (r_sq_n[j] >= trial);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_n[j+1]   <= take ? r_sq_n[j] - trial : r_sq_n[j];
                r_sq_res[j+1] <= take ? (r_sq_res[j] >> 1) + BIT : r_sq_res[j] >> 1;
                r_sq_car[j+1] <= r_sq_car[j];
            end
        end
    end

    // stage e and arctangent pipeline, with the two dividers riding along
    logic signed [34:0] r_cd_px  [0:CORDIC_STEPS];
    logic signed [34:0] r_cd_py  [0:CORDIC_STEPS];
    logic signed [33:0] r_cd_ang [0:CORDIC_STEPS];
    logic [31:0]        r_cd_rho [0:CORDIC_STEPS];
    logic [31:0]        r_cd_rc  [0:CORDIC_STEPS];
    logic [31:0]        r_cd_rs  [0:CORDIC_STEPS];
    logic [24:0]        r_cd_qc  [0:CORDIC_STEPS];
    logic [24:0]        r_cd_qs  [0:CORDIC_STEPS];
    t_car               r_cd_car [0:CORDIC_STEPS];

    logic [31:0] e_rho, e_a;
    t_car        e_car;
    assign e_rho = r_sq_res[SQRT_STEPS][31:0];
    assign e_car = r_sq_car[SQRT_STEPS];
    assign e_a   = e_rho >> e_car.k;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // negative z starts rotated by a quarter turn
            r_cd_px[0]  <= e_car.sz ? $signed({3'd0, e_a}) : $signed({3'd0, e_car.b_s});
            r_cd_py[0]  <= e_car.sz ? $signed({3'd0, e_car.b_s}) : $signed({3'd0, e_a});
            r_cd_ang[0] <= e_car.sz ? HALF_PI_Q30 : '0;
            r_cd_rho[0] <= e_rho;
            r_cd_rc[0]  <= e_car.x_n;
            r_cd_rs[0]  <= e_car.y_n;
            r_cd_qc[0]  <= '0;
            r_cd_qs[0]  <= '0;
            r_cd_car[0] <= e_car;
        end
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        logic signed [34:0] dx, dy;
        logic [32:0]        cand_c, cand_s;
        logic               ge_c, ge_s;
        logic [31:0]        n_rc, n_rs;
        logic [24:0]        n_qc, n_qs;

        assign dx = r_cd_py[j] >>> j;
        assign dy = r_cd_px[j] >>> j;

        if (j < DIV_STEPS) begin : g_div
            localparam logic [24:0] QBIT = 25'd1 << (DIV_STEPS - 1 - j);
            assign cand_c = (j == 0) ? {1'b0, r_cd_rc[j]} : {r_cd_rc[j], 1'b0};
            assign cand_s = (j == 0) ? {1'b0, r_cd_rs[j]} : {r_cd_rs[j], 1'b0};
            assign ge_c   = (cand_c >= {1'b0, r_cd_rho[j]});
            assign ge_s   = (cand_s >= {1'b0, r_cd_rho[j]});
            assign n_rc   = ge_c ? 32'(cand_c - {1'b0, r_cd_rho[j]}) : cand_c[31:0];
            assign n_rs   = ge_s ? 32'(cand_s - {1'b0, r_cd_rho[j]}) : cand_s[31:0];
            assign n_qc   = ge_c ? (r_cd_qc[j] | QBIT) : r_cd_qc[j];
            assign n_qs   = ge_s ? (r_cd_qs[j] | QBIT) : r_cd_qs[j];
        end else begin : g_nodiv
            assign cand_c = '0;
            assign cand_s = '0;
            assign ge_c   = 1'b0;
            assign ge_s   = 1'b0;
            assign n_rc   = r_cd_rc[j];
            assign n_rs   = r_cd_rs[j];
            assign n_qc   = r_cd_qc[j];
            assign n_qs   = r_cd_qs[j];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_cd_py[j][34]) begin
                    r_cd_px[j+1]  <= r_cd_px[j] + dx;
                    r_cd_py[j+1]  <= r_cd_py[j] - dy;
                    r_cd_ang[j+1] <= r_cd_ang[j] + atan_q30(j);
                end else begin
                    r_cd_px[j+1]  <= r_cd_px[j] - dx;
                    r_cd_py[j+1]  <= r_cd_py[j] + dy;
                    r_cd_ang[j+1] <= r_cd_ang[j] - atan_q30(j);
                end
                r_cd_rho[j+1] <= r_cd_rho[j];
                r_cd_rc[j+1]  <= n_rc;
                r_cd_rs[j+1]  <= n_rs;
                r_cd_qc[j+1]  <= n_qc;
                r_cd_qs[j+1]  <= n_qs;
                r_cd_car[j+1] <= r_cd_car[j];
            end
        end
    end

    // stage f: clamp angle, on-axis case, signed direction cosines
    logic signed [33:0] f_ang;
    logic [31:0]        f_theta;
    logic signed [25:0] f_cos, f_sin;
    t_car               f_car;
    t_pol               r_f_pol;

    always_comb begin
        f_car = r_cd_car[CORDIC_STEPS];
        f_ang = r_cd_ang[CORDIC_STEPS];
        if (f_ang < 0) begin
            f_ang = '0;
        end else if (f_ang > PI_Q30) begin
            f_ang = PI_Q30;
        end
        if (f_car.zero) begin
            f_theta = f_car.sz ? PI_Q30[31:0] : 32'd0;
            f_cos   = 26'sd16777216;
            f_sin   = '0;
        end else begin
            f_theta = f_ang[31:0];
            f_cos   = f_car.sx ? -$signed({1'b0, r_cd_qc[CORDIC_STEPS]})
                               : $signed({1'b0, r_cd_qc[CORDIC_STEPS]});
            f_sin   = f_car.sy ? -$signed({1'b0, r_cd_qs[CORDIC_STEPS]})
                               : $signed({1'b0, r_cd_qs[CORDIC_STEPS]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_pol <= '{t: f_theta[31:6], t2: '0, cosv: f_cos, sinv: f_sin};
        end
    end

    // stages g, h: theta squared
    t_pol        r_g_pol, r_h_pol;
    logic [51:0] r_g_tt;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_pol <= r_f_pol;
            r_g_tt  <= r_f_pol.t * r_f_pol.t;
            r_h_pol <= '{t: r_g_pol.t, t2: r_g_tt[51:24],
                         cosv: r_g_pol.cosv, sinv: r_g_pol.sinv};
        end
    end

    // horner steps in theta squared, two stages each
    logic signed [52:0] r_hn_lo  [0:HORNER_STEPS-1];
    logic signed [51:0] r_hn_hi  [0:HORNER_STEPS-1];
    t_pol               r_hn_pm  [0:HORNER_STEPS-1];
    t_mop               r_hn_a   [1:HORNER_STEPS];
    t_pol               r_hn_pol [1:HORNER_STEPS];

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
        t_mop               coef;
        t_mop               a_in;
        t_pol               pol_in;
        logic signed [73:0] prod;
        if (j == 0) begin : g_first
            assign a_in   = t_mop'($signed(r_k3));
            assign pol_in = r_h_pol;
        end else begin : g_next
            assign a_in   = r_hn_a[j];
            assign pol_in = r_hn_pol[j];
        end
        if (j == 0) begin : g_c2
            assign coef = t_mop'($signed(r_k2));
        end else if (j == 1) begin : g_c1
            assign coef = t_mop'($signed(r_k1));
        end else if (j == 2) begin : g_c0
            assign coef = t_mop'($signed(r_k0));
        end else begin : g_one
            assign coef = t_mop'(1) <<< 21;
        end
        assign prod = mul_join(r_hn_lo[j], r_hn_hi[j]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hn_lo[j]    <= mul_lo(a_in, t_mcoef'({2'b00, pol_in.t2}));
                r_hn_hi[j]    <= mul_hi(a_in, t_mcoef'({2'b00, pol_in.t2}));
                r_hn_pm[j]    <= pol_in;
                r_hn_a[j+1]   <= coef + prod[67:24];
                r_hn_pol[j+1] <= r_hn_pm[j];
            end
        end
    end

    // radius r = t * a, then direction, then focal scaling
    logic signed [52:0] r_r_lo, r_pu_lo, r_pv_lo, r_u_lo, r_v_lo;
    logic signed [51:0] r_r_hi, r_pu_hi, r_pv_hi, r_u_hi, r_v_hi;
    t_pol               r_r_pol, r_rr_pol;
    t_mop               r_r, r_pu, r_pv;
    logic signed [73:0] r_prod, pu_prod, pv_prod, u_prod, v_prod;
    logic signed [52:0] u_sum, v_sum;
    logic [31:0]        r_u, r_v;
    logic               r_sat;
    logic [31:0]        n_u, n_v;
    logic               n_sat;

    assign r_prod  = mul_join(r_r_lo, r_r_hi);
    assign pu_prod = mul_join(r_pu_lo, r_pu_hi);
    assign pv_prod = mul_join(r_pv_lo, r_pv_hi);
    assign u_prod  = mul_join(r_u_lo, r_u_hi);
    assign v_prod  = mul_join(r_v_lo, r_v_hi);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_lo   <= mul_lo(r_hn_a[HORNER_STEPS],
                               t_mcoef'({4'd0, r_hn_pol[HORNER_STEPS].t}));
            r_r_hi   <= mul_hi(r_hn_a[HORNER_STEPS],
                               t_mcoef'({4'd0, r_hn_pol[HORNER_STEPS].t}));
            r_r_pol  <= r_hn_pol[HORNER_STEPS];
            r_r      <= r_prod[67:24];
            r_rr_pol <= r_r_pol;
            r_pu_lo  <= mul_lo(r_r, t_mcoef'(r_rr_pol.cosv));
            r_pu_hi  <= mul_hi(r_r, t_mcoef'(r_rr_pol.cosv));
            r_pv_lo  <= mul_lo(r_r, t_mcoef'(r_rr_pol.sinv));
            r_pv_hi  <= mul_hi(r_r, t_mcoef'(r_rr_pol.sinv));
            r_pu     <= pu_prod[67:24];
            r_pv     <= pv_prod[67:24];
            r_u_lo   <= mul_lo(r_pu, t_mcoef'({6'd0, r_fx}));
            r_u_hi   <= mul_hi(r_pu, t_mcoef'({6'd0, r_fx}));
            r_v_lo   <= mul_lo(r_pv, t_mcoef'({6'd0, r_fy}));
            r_v_hi   <= mul_hi(r_pv, t_mcoef'({6'd0, r_fy}));
            r_u      <= n_u;
            r_v      <= n_v;
            r_sat    <= n_sat;
        end
    end

    // add principal point and clip to 32 bits
    always_comb begin
        u_sum = u_prod[73:21] + $signed({29'd0, r_cx});
        v_sum = v_prod[73:21] + $signed({29'd0, r_cy});
        n_sat = 1'b0;
        if (u_sum > 53'sd2147483647) begin
            n_u   = 32'h7fff_ffff;
            n_sat = 1'b1;
        end else if (u_sum < -53'sd2147483648) begin
            n_u   = 32'h8000_0000;
            n_sat = 1'b1;
        end else begin
            n_u = u_sum[31:0];
        end
        if (v_sum > 53'sd2147483647) begin
            n_v   = 32'h7fff_ffff;
            n_sat = 1'b1;
        end else if (v_sum < -53'sd2147483648) begin
            n_v   = 32'h8000_0000;
            n_sat = 1'b1;
        end else begin
            n_v = v_sum[31:0];
        end
    end

    assign m_axis_tdata = {r_v, r_u};
    assign m_axis_tuser = r_sat;

endmodule

`default_nettype wire

[tb/fpp_checker.sv]
// pixel predictor and scoreboard for the fisheye projection block
`timescale 1ns / 1ps
`default_nettype none

module fpp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_pt_valid,
    input  wire logic        i_pt_ready,
    input  wire logic [95:0] i_pt_data,
    input  wire logic        i_px_valid,
    input  wire logic        i_px_ready,
    input  wire logic [63:0] i_px_data,
    input  wire logic        i_px_sat,
    output int               o_fail_count,
    output int               o_pending
);
    import fpp_pkg::*;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        sat;
    } t_pixel;

    logic [23:0] fx, fy, cx, cy;
    logic [23:0] k0, k1, k2, k3;
    t_pixel pixel_q[$];

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clip(input longint w, inout logic flag);
        if (w > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fffffff;
        end
        if (w < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return w[31:0];
    endfunction

    function automatic t_pixel project(input logic [95:0] pt);
        longint x, y, z, cosv, sinv, theta, t, t2, a, r, pu, pv, px, py, ang, dx, dy;
        longint unsigned ax, ay, az, xs, ys, rho, aa, bb;
        int s;
        t_pixel p;
        logic flag;
        x = longint'($signed(pt[31:0]));
        y = longint'($signed(pt[63:32]));
        z = longint'($signed(pt[95:64]));
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        flag = 1'b0;
        if (ax == 0 && ay == 0) begin
            cosv = 64'sd1 << 24;
            sinv = 0;
            theta = z < 0 ? longint'(PI_Q30) : 0;
        end else begin
            s = 0;
            while (((ax | ay) << s) < (64'd1 << 30)) s++;
            xs = ax << s;
            ys = ay << s;
            rho = isqrt(xs * xs + ys * ys);
            cosv = longint'((xs << 24) / rho);
            sinv = longint'((ys << 24) / rho);
            if (x < 0) cosv = -cosv;
            if (y < 0) sinv = -sinv;
            aa = rho;
            bb = az << s;
            while ((aa | bb) >= (64'd1 << 32)) begin
                aa >>= 1;
                bb >>= 1;
            end
            if (z >= 0) begin
                px = bb; py = aa; ang = 0;
            end else begin
                px = aa; py = bb; ang = longint'(HALF_PI_Q30);
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0) begin
                    px += dx; py -= dy; ang += longint'(atan_q30(i));
                end else begin
                    px -= dx; py += dy; ang -= longint'(atan_q30(i));
                end
            end
            if (ang < 0) ang = 0;
            if (ang > longint'(PI_Q30)) ang = longint'(PI_Q30);
            theta = ang;
        end
        t = theta >>> 6;
        t2 = (t * t) >>> 24;
        a = longint'($signed(k3));
        a = longint'($signed(k2)) + ((t2 * a) >>> 24);
        a = longint'($signed(k1)) + ((t2 * a) >>> 24);
        a = longint'($signed(k0)) + ((t2 * a) >>> 24);
        a = (64'sd1 << 21) + ((t2 * a) >>> 24);
        r = (t * a) >>> 24;
        pu = (r * cosv) >>> 24;
        pv = (r * sinv) >>> 24;
        p.u = clip(((longint'(fx) * pu) >>> 21) + longint'(cx), flag);
        p.v = clip(((longint'(fy) * pv) >>> 21) + longint'(cy), flag);
        p.sat = flag;
        return p;
    endfunction

    assign o_pending = pixel_q.size();

    always_ff @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            fx <= 24'd256; fy <= 24'd256; cx <= '0; cy <= '0;
            k0 <= '0; k1 <= '0; k2 <= '0; k3 <= '0;
            pixel_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FOCAL_X:  fx <= i_cfg_data;
                    CFG_FOCAL_Y:  fy <= i_cfg_data;
                    CFG_CENTER_X: cx <= i_cfg_data;
                    CFG_CENTER_Y: cy <= i_cfg_data;
                    CFG_DIST_K0:  k0 <= i_cfg_data;
                    CFG_DIST_K1:  k1 <= i_cfg_data;
                    CFG_DIST_K2:  k2 <= i_cfg_data;
                    CFG_DIST_K3:  k3 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pt_valid && i_pt_ready) pixel_q.push_back(project(i_pt_data));
            if (i_px_valid && i_px_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("pixel item with none expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (want.u !== i_px_data[31:0] || want.v !== i_px_data[63:32]
                            || want.sat !== i_px_sat) begin
                        o_fail_count <= o_fail_count + 1;
                        if (want.u !== i_px_data[31:0])
                            $error("pixel_u expected %h got %h", want.u, i_px_data[31:0]);
                        if (want.v !== i_px_data[63:32])
                            $error("pixel_v expected %h got %h", want.v, i_px_data[63:32]);
                        if (want.sat !== i_px_sat)
                            $error("saturated expected %b got %b", want.sat, i_px_sat);
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

[tb/tb_fisheye_point_projection_top.sv]
// stimulus and verdict for the fisheye projection block
`timescale 1ns / 1ps
`default_nettype none

module tb_fisheye_point_projection_top;
    import fpp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;  // point_x, point_y, point_z
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;  // pixel_u, pixel_v
    logic        m_axis_tuser;  // saturated
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_stall;
    bit          hold_off;
    longint      cycles;

    fisheye_point_projection_top dut (.*);

    fpp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_pt_valid(s_axis_tvalid), .i_pt_ready(s_axis_tready), .i_pt_data(s_axis_tdata),
        .i_px_valid(m_axis_tvalid), .i_px_ready(m_axis_tready), .i_px_data(m_axis_tdata),
        .i_px_sat(m_axis_tuser), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 600000) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [31:0] coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            2: return 32'($signed($urandom_range(1 << 14)) - (1 << 13));
            3: return '0;
            4: return $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
            default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    task automatic send(input logic [95:0] pt);
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pt;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // the enable stays high across a sequence of writes and is dropped by the caller
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [23:0] f0, input logic [23:0] f1,
                            input logic [23:0] c0, input logic [23:0] c1,
                            input logic [23:0] d0, input logic [23:0] d1,
                            input logic [23:0] d2, input logic [23:0] d3);
        write_reg(CFG_FOCAL_X, f0);
        write_reg(CFG_FOCAL_Y, f1);
        write_reg(CFG_CENTER_X, c0);
        write_reg(CFG_CENTER_Y, c1);
        write_reg(CFG_DIST_K0, d0);
        write_reg(CFG_DIST_K1, d1);
        write_reg(CFG_DIST_K2, d2);
        write_reg(CFG_DIST_K3, d3);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_burst(input int n);
        for (int i = 0; i < n; i++) send({coord(), coord(), coord()});
    endtask

    localparam logic [31:0] MAXP = 32'h7fffffff;
    localparam logic [31:0] MINN = 32'h80000000;
    localparam logic [31:0] ONE  = 32'h00010000;

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero point, axis points, behind camera, extremes
        send({ONE, 32'd0, 32'd0});
        send({32'd0, 32'd0, 32'd0});
        send({MINN, 32'd0, 32'd0});
        send({ONE, 32'd0, ONE});
        send({ONE, ONE, 32'd0});
        send({-ONE, ONE, -ONE});
        send({MAXP, MAXP, MAXP});
        send({MINN, MINN, MINN});
        send({MAXP, MINN, 32'd1});
        send({32'd0, 32'd1, 32'hffffffff});
        send({MINN, 32'hffffffff, 32'd0});
        send({32'd0, MINN, MAXP});
        drain();

        set_regs(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        send({MINN, MAXP, 32'd5});
        send({ONE, MINN, MAXP});
        send({-ONE, ONE, ONE});
        send({MINN, MINN, 32'd0});
        random_burst(150);
        drain();

        set_regs(24'd1, 24'd1, 24'd0, 24'd0,
                 24'h800000, 24'h800000, 24'h800000, 24'h800000);
        send({MINN, MAXP, MINN});
        send({32'd0, 32'd0, 32'd0});
        random_burst(150);
        drain();

        set_regs(24'd76800, 24'd76800, 24'd163840, 24'd122880,
                 24'h1f0000, 24'hfc0000, 24'h020000, 24'hffc000);
        random_burst(300);
        send_idle = 65;
        random_burst(250);
        send_idle = 0;
        recv_stall = 65;
        random_burst(250);
        drain();

        set_regs(24'd300000, 24'd2000, 24'h800000, 24'd0,
                 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        send_idle = 20;
        recv_stall = 20;
        random_burst(250);
        send_idle = 0;
        recv_stall = 0;
        // long receiver hold-off while the sender keeps pushing
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_burst(200);
        join
        drain();

        set_regs(24'd256, 24'd256, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        random_burst(150);
        drain();

        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
